// ----- design/tec_pkg.sv -----
// shared types, constants and helpers of the tab expand/compress block
`timescale 1ns / 1ps

package tec_pkg;

  localparam int COLUMN_BITS = 16;
  localparam int LEAD_STEP   = 8;
  localparam int START_BITS  = 16;
  localparam int WIDTH_BITS  = 6;
  localparam int HOLD_BITS   = 6;
  localparam int MAX_OUT     = 64;
  localparam int CNT_BITS    = $clog2(MAX_OUT + 1);
  localparam int CMP_BITS    = ((COLUMN_BITS > START_BITS) ? COLUMN_BITS : START_BITS) + 1;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = START_BITS;

  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_SP  = 8'd32;

  localparam logic [HOLD_BITS-1:0]  HOLD_MAX      = '1;
  localparam logic [WIDTH_BITS-1:0] TAB_WIDTH_RST = WIDTH_BITS'(8);

  typedef logic [COLUMN_BITS-1:0] col_t;
  typedef logic [CMP_BITS-1:0]    cmp_t;

  localparam col_t COL_MAX = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODE         = 2'd0,
    REG_START_COLUMN = 2'd1,
    REG_TAB_WIDTH    = 2'd2
  } reg_idx_e;

  typedef enum logic {
    MODE_DETAB = 1'b0,
    MODE_ENTAB = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                  mode;
    logic [START_BITS-1:0]  start_column;
    logic [WIDTH_BITS-1:0]  tab_width;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } item_t;

  // what one item emits: an optional tab, a run of spaces, an optional byte
  typedef struct packed {
    logic                tab;
    logic [CNT_BITS-1:0] spaces;
    logic                has_char;
    logic [7:0]          chr;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic       free;
    logic [7:0] out_char;
    logic       last;
  } emit_stat_t;

  function automatic col_t sat_add(col_t a, cmp_t b);
    cmp_t s;
    s = cmp_t'(a) + b;
    return (s > cmp_t'(COL_MAX)) ? COL_MAX : s[COLUMN_BITS-1:0];
  endfunction

endpackage

// ----- design/tec_if.sv -----
// item channels of the tab expand/compress block
`timescale 1ns / 1ps

interface tec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_text;

  modport source (output valid, output in_char, output end_of_text, input ready);
  modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface tec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

// ----- design/tab_expand_compress.sv -----
// top level of the tab expand/compress byte stream converter
`timescale 1ns / 1ps

// tab expand/compress: a byte stream converter. mode 0 expands each tab into
// spaces up to the next tab stop; mode 1 holds runs of spaces and replaces a
// run that reaches a stop with one tab. stops fall every 8 columns up to
// start_column, then every tab_width columns. an item with end_of_text set
// releases held spaces and resets the column. each item passes an input
// register, then combinational conversion logic loads a result job into
// the output register, which plays it out one byte per cycle while the
// sink is ready; an item whose job is at most one byte then keeps the
// stream at one item per cycle. an item that produces n bytes holds the
// output register until all n are taken, and the input register lets the
// next item wait there meanwhile. items that produce nothing pass without
// touching the output. configuration is to be written by the user only
// while the block is idle; the block itself does not enforce this.

module tab_expand_compress import tec_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  tec_in_if.sink                   in_i,
  tec_out_if.source                out_o
);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= MODE_DETAB;
      cfg_q.start_column <= '0;
      cfg_q.tab_width    <= TAB_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:         cfg_q.mode         <= mode_e'(cfg_wdata_i[0]);
        REG_START_COLUMN: cfg_q.start_column <= cfg_wdata_i[START_BITS-1:0];
        REG_TAB_WIDTH:    cfg_q.tab_width    <= cfg_wdata_i[WIDTH_BITS-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // input register
  logic       in_vq;
  item_t      item_q;
  logic       move;
  logic       load;
  logic       in_take;
  logic       out_take;
  logic       job_empty;
  job_t       job;
  emit_stat_t stat;

  assign in_i.ready = !in_vq || move;
  assign in_take    = in_i.valid && in_i.ready;
  assign out_take   = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_take) begin
      in_vq <= 1'b1;
    end else if (move) begin
      in_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= '{in_char: in_i.in_char, end_of_text: in_i.end_of_text};
    end
  end

  // conversion: state moves on when the item leaves the input register
  tec_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (move),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .job_o  (job)
  );

  // an item with no output never waits for the result register
  assign job_empty = !job.tab && (job.spaces == '0) && !job.has_char;
  assign move      = in_vq && (job_empty || stat.free);
  assign load      = move && !job_empty;

  tec_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .job_i  (job),
    .take_i (out_take),
    .stat_o (stat)
  );

  assign out_o.valid    = stat.valid;
  assign out_o.out_char = stat.out_char;
  assign out_o.last     = stat.last;

  // a job is only loaded once the previous one has fully gone out
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> stat.free)
    else $error("job loaded over a pending result");

  // a loaded job shows a result in the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_o.valid)
    else $error("loaded job produced no result");

  // a burst keeps going until its last byte
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !out_o.last) |=> out_o.valid)
    else $error("result burst ended without last");

endmodule

// ----- design/tec_step.sv -----
// column and tab-stop state with the per-item conversion logic
`timescale 1ns / 1ps

module tec_step import tec_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output job_t  job_o
);

  col_t                 column_q, column_d;
  col_t                 stop_q, stop_d;
  logic [HOLD_BITS-1:0] held_q, held_d;

  cmp_t                  start_ext;
  logic [WIDTH_BITS-1:0] width_eff;
  logic                  reached;
  col_t                  stop_adv, stop1, col_inc, gap;
  logic [HOLD_BITS-1:0]  held1;

  always_comb begin
    start_ext = cmp_t'(cfg_i.start_column);
    width_eff = (cfg_i.tab_width == '0) ? WIDTH_BITS'(1) : cfg_i.tab_width;
    reached   = column_q >= stop_q;
    if (cmp_t'(column_q) < start_ext) begin
      if (cmp_t'(stop_q) + cmp_t'(LEAD_STEP) < start_ext) begin
        stop_adv = sat_add(stop_q, cmp_t'(LEAD_STEP));
      end else begin
        stop_adv = start_ext[COLUMN_BITS-1:0];
      end
    end else begin
      stop_adv = sat_add(stop_q, cmp_t'(width_eff));
    end
    stop1   = reached ? stop_adv : stop_q;
    col_inc = sat_add(column_q, cmp_t'(1));
    gap     = stop1 - column_q;
    held1   = reached ? '0 : held_q;
  end

  always_comb begin
    column_d = column_q;
    stop_d   = stop1;
    held_d   = held_q;
    job_o    = '{tab: 1'b0, spaces: '0, has_char: 1'b0, chr: item_i.in_char};
    if (item_i.end_of_text) begin
      job_o.spaces = CNT_BITS'(held_q);
      column_d     = '0;
      stop_d       = '0;
      held_d       = '0;
    end else if (cfg_i.mode == MODE_DETAB) begin
      case (item_i.in_char)
        CH_TAB: begin
          if (column_q < stop1) begin
            // one tab emits at most a full output burst of spaces
            if (cmp_t'(gap) > cmp_t'(MAX_OUT)) begin
              job_o.spaces = CNT_BITS'(MAX_OUT);
            end else begin
              job_o.spaces = gap[CNT_BITS-1:0];
            end
            column_d = column_q + col_t'(job_o.spaces);
          end
        end
        CH_NL: begin
          column_d       = '0;
          stop_d         = '0;
          job_o.has_char = 1'b1;
        end
        default: begin
          column_d       = col_inc;
          job_o.has_char = 1'b1;
        end
      endcase
    end else begin
      job_o.tab = reached && (held_q != '0);
      held_d    = held1;
      if (item_i.in_char == CH_SP) begin
        // full hold passes the space straight through
        if (held1 < HOLD_MAX) begin
          held_d = held1 + HOLD_BITS'(1);
        end else begin
          job_o.spaces = CNT_BITS'(1);
        end
        column_d = col_inc;
      end else begin
        job_o.has_char = 1'b1;
        job_o.spaces   = CNT_BITS'(held1);
        held_d         = '0;
        case (item_i.in_char)
          CH_TAB: column_d = stop1;
          CH_NL: begin
            column_d     = '0;
            stop_d       = '0;
            job_o.spaces = '0;
          end
          default: column_d = col_inc;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      stop_q   <= '0;
      held_q   <= '0;
    end else if (step_i) begin
      column_q <= column_d;
      stop_q   <= stop_d;
      held_q   <= held_d;
    end
  end

endmodule

// ----- design/tec_emit.sv -----
// result register that plays out one job a byte per cycle while the sink takes
`timescale 1ns / 1ps

module tec_emit import tec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  job_t       job_i,
  input  logic       take_i,
  output emit_stat_t stat_o
);

  job_t job_q, job_d;

  always_comb begin
    stat_o.valid = job_q.tab || (job_q.spaces != '0) || job_q.has_char;
    if (job_q.tab) begin
      stat_o.out_char = CH_TAB;
      stat_o.last     = (job_q.spaces == '0) && !job_q.has_char;
    end else if (job_q.spaces != '0) begin
      stat_o.out_char = CH_SP;
      stat_o.last     = (job_q.spaces == CNT_BITS'(1)) && !job_q.has_char;
    end else begin
      stat_o.out_char = job_q.chr;
      stat_o.last     = 1'b1;
    end
    stat_o.free = !stat_o.valid || (take_i && stat_o.last);
  end

  always_comb begin
    job_d = job_q;
    if (load_i) begin
      job_d = job_i;
    end else if (take_i) begin
      if (job_q.tab) begin
        job_d.tab = 1'b0;
      end else if (job_q.spaces != '0) begin
        job_d.spaces = job_q.spaces - CNT_BITS'(1);
      end else begin
        job_d.has_char = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q.tab      <= 1'b0;
      job_q.spaces   <= '0;
      job_q.has_char <= 1'b0;
      job_q.chr      <= '0;
    end else begin
      job_q.tab      <= job_d.tab;
      job_q.spaces   <= job_d.spaces;
      job_q.has_char <= job_d.has_char;
      job_q.chr      <= job_d.chr;
    end
  end

endmodule
